// ===== src/timestamp_frame_pair_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp frame pair matcher
// Clocked, reset-gated property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_FRAME_PAIR_MATCHER_MACROS_SVH
`define TIMESTAMP_FRAME_PAIR_MATCHER_MACROS_SVH

// same-cycle implication
`define TFPM_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tfpm: same-cycle check failed");

// next-cycle implication
`define TFPM_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tfpm: next-cycle check failed");

`endif

// ===== src/tfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpm_pkg
// Field widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tfpm_pkg;

   localparam int TAG_W  = 16;
   localparam int SEC_W  = 32;
   localparam int USEC_W = 20;
   localparam int WIN_W  = 20;
   localparam int PAIR_W = 16;
   localparam int TIME_W = 52;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = 7;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [WIN_W-1:0]  WINDOW_RESET = 20'd33333;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] total;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic enqueue;
      logic scan_init;
      logic scan_run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic empty;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/timestamp_frame_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// Timestamp frame pair matcher
// Pairs color and depth frame notices whose timestamps lie within a window.
// ----------------------------------------------------------------------------
// Each frame notice goes into the ring queue of its stream (a full queue loses
// its oldest entry and flags dropped); the block then looks for the oldest
// color frame that has a depth frame within window_us microseconds, taking the
// oldest such depth frame, reports both tags with a running pair number, and
// retires both queues up to the pair. Every notice yields one result word.
// Steps: accept, timestamp conversion, enqueue, scan start, a pair scan that
// examines one color/depth pair per cycle, and result hand-off. A result still
// waiting in the output register holds back the next result and the input; a
// new notice is taken only after the last one's result is handed off.
// After reset both queues are empty and window_us is 33333.
`default_nettype none

`include "timestamp_frame_pair_matcher_macros.svh"

module timestamp_frame_pair_matcher #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // frame_tag[15:0], time_sec[47:16], time_usec[67:48], zero pad [71:68]
   input  wire logic [tfpm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // stream_id (0 color, 1 depth)
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // color_tag[15:0], depth_tag[31:16], pair_number[47:32], dropped[48], pad [55:49]
   output logic [tfpm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // matched
   output logic                                  rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tfpm_pkg::WIN_W-1:0]       csr_data
);
   import tfpm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tfpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tfpm_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `TFPM_ASSERT_IMPL(a_no_accept_in_scan, cmd.scan_run, !req_tready)
   `TFPM_ASSERT_NEXT(a_emit_shows_word, cmd.emit, rsp_tvalid)
   `TFPM_ASSERT_NEXT(a_stop_on_first_hit, cmd.scan_run && stat.hit, !cmd.scan_run)
   `TFPM_ASSERT_NEXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire

// ===== src/tfpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tfpm_ctrl
// Sequencer: accept, timestamp conversion, enqueue, pair scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  tfpm_pkg::stat_type      stat,
   output tfpm_pkg::cmd_type       cmd
);
   import tfpm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_ENQ   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.capture   = req_tvalid && req_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ENQ;
         end
         S_ENQ: begin
            cmd.enqueue = 1'b1;
            state_in    = S_START;
         end
         S_START: begin
            // nothing to pair with when either queue is empty
            if (stat.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.hit || stat.last) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tfpm_datapath.sv =====
// ----------------------------------------------------------------------------
// tfpm_datapath
// Frame queues as ring buffers, timestamp arithmetic, window compare, output
// register and the window register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpm_datapath #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  tfpm_pkg::cmd_type                        cmd,
   output tfpm_pkg::stat_type                       stat,
   input  wire logic                                req_tuser,
   input  wire logic [tfpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tfpm_pkg::WIN_W-1:0]          csr_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [tfpm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tuser
);
   import tfpm_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IW:0]   DEPTH_N    = (IW+1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

   // base + step modulo the depth, with base below the depth and step at most the depth
   function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [IW:0] step);
      logic [IW+1:0] sum;
      sum = {2'b00, base} + {1'b0, step};
      if (sum >= {1'b0, DEPTH_N}) sum = sum - {1'b0, DEPTH_N};
      return sum[IW-1:0];
   endfunction

   logic                    sid_ff, sid_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [SEC_W-1:0]        sec_ff, sec_in;
   logic [USEC_W-1:0]       usec_ff, usec_in;
   logic [TIME_W-1:0]       prod_ff, prod_in;
   logic [WIN_W-1:0]        window_ff, window_in;

   logic [IW-1:0]           head_c_ff, head_c_in, head_d_ff, head_d_in;
   logic [CW-1:0]           cnt_c_ff, cnt_c_in, cnt_d_ff, cnt_d_in;
   logic [IW-1:0]           ci_ff, ci_in, di_ff, di_in;
   logic [PAIR_W-1:0]       pair_ff, pair_in;

   logic                    match_ff, match_in;
   logic                    drop_ff, drop_in;
   logic [TAG_W-1:0]        ctag_ff, ctag_in, dtag_ff, dtag_in;
   logic [PAIR_W-1:0]       pnum_ff, pnum_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   entry_type               color_mem_ff [QUEUE_DEPTH];
   entry_type               depth_mem_ff [QUEUE_DEPTH];
   entry_type               color_rd_ff, depth_rd_ff;
   entry_type               new_entry;

   logic                    full_c, full_d;
   logic [IW-1:0]           tail_c, tail_d, addr_c, addr_d;
   logic                    we_c, we_d;
   logic [IW:0]             ci_step, di_step;
   logic                    ci_last, di_last, hit;
   logic [TIME_W:0]         ct_ext, dt_ext, ct_win, dt_win;

   assign csr_ready = 1'b1;

   assign full_c    = (cnt_c_ff == COUNT_FULL);
   assign full_d    = (cnt_d_ff == COUNT_FULL);
   // a full ring overwrites its oldest entry
   assign tail_c    = full_c ? head_c_ff : ring_add(head_c_ff, {1'b0, cnt_c_ff[IW-1:0]});
   assign tail_d    = full_d ? head_d_ff : ring_add(head_d_ff, {1'b0, cnt_d_ff[IW-1:0]});
   assign we_c      = cmd.enqueue && !sid_ff;
   assign we_d      = cmd.enqueue && sid_ff;
   assign new_entry = '{tag: tag_ff, total: prod_ff + TIME_W'(usec_ff)};

   assign ci_step = {1'b0, ci_ff} + (IW+1)'(1);
   assign di_step = {1'b0, di_ff} + (IW+1)'(1);
   assign ci_last = (CW'(ci_step) == cnt_c_ff);
   assign di_last = (CW'(di_step) == cnt_d_ff);

   // |ct - dt| <= window, as two bounded compares
   assign ct_ext = {1'b0, color_rd_ff.total};
   assign dt_ext = {1'b0, depth_rd_ff.total};
   assign ct_win = ct_ext + (TIME_W+1)'(window_ff);
   assign dt_win = dt_ext + (TIME_W+1)'(window_ff);
   assign hit    = (ct_ext <= dt_win) && (dt_ext <= ct_win);

   assign stat.hit      = hit;
   assign stat.last     = ci_last && di_last;
   assign stat.empty    = (cnt_c_ff == '0) || (cnt_d_ff == '0);
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sid_in       = sid_ff;
      tag_in       = tag_ff;
      sec_in       = sec_ff;
      usec_in      = usec_ff;
      prod_in      = TIME_W'(sec_ff) * TIME_W'(USEC_PER_SEC);
      window_in    = window_ff;
      head_c_in    = head_c_ff;
      head_d_in    = head_d_ff;
      cnt_c_in     = cnt_c_ff;
      cnt_d_in     = cnt_d_ff;
      ci_in        = ci_ff;
      di_in        = di_ff;
      pair_in      = pair_ff;
      match_in     = match_ff;
      drop_in      = drop_ff;
      ctag_in      = ctag_ff;
      dtag_in      = dtag_ff;
      pnum_in      = pnum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) window_in = csr_data;

      if (cmd.capture) begin
         sid_in   = req_tuser;
         tag_in   = req_tdata[TAG_W-1:0];
         sec_in   = req_tdata[TAG_W+SEC_W-1:TAG_W];
         usec_in  = req_tdata[TAG_W+SEC_W+USEC_W-1:TAG_W+SEC_W];
         match_in = 1'b0;
         drop_in  = 1'b0;
         ctag_in  = '0;
         dtag_in  = '0;
         pnum_in  = '0;
      end

      if (cmd.enqueue) begin
         if (!sid_ff) begin
            if (full_c) begin
               head_c_in = ring_add(head_c_ff, (IW+1)'(1));
               drop_in   = 1'b1;
            end else begin
               cnt_c_in = cnt_c_ff + CW'(1);
            end
         end else begin
            if (full_d) begin
               head_d_in = ring_add(head_d_ff, (IW+1)'(1));
               drop_in   = 1'b1;
            end else begin
               cnt_d_in = cnt_d_ff + CW'(1);
            end
         end
      end

      if (cmd.scan_init) begin
         ci_in = '0;
         di_in = '0;
      end

      if (cmd.scan_run) begin
         if (hit) begin
            // drop both queues up to and including the matched pair
            match_in  = 1'b1;
            ctag_in   = color_rd_ff.tag;
            dtag_in   = depth_rd_ff.tag;
            pnum_in   = pair_ff;
            pair_in   = pair_ff + PAIR_W'(1);
            head_c_in = ring_add(head_c_ff, ci_step);
            head_d_in = ring_add(head_d_ff, di_step);
            cnt_c_in  = cnt_c_ff - CW'(ci_step);
            cnt_d_in  = cnt_d_ff - CW'(di_step);
         end else if (!(ci_last && di_last)) begin
            if (di_last) begin
               di_in = '0;
               ci_in = ci_step[IW-1:0];
            end else begin
               di_in = di_step[IW-1:0];
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, drop_ff, pnum_ff, dtag_ff, ctag_ff};
         rsp_user_in  = match_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // read addresses follow the next scan indices, so read data lines up with ci_ff/di_ff
   assign addr_c = ring_add(head_c_ff, {1'b0, ci_in});
   assign addr_d = ring_add(head_d_ff, {1'b0, di_in});

   always_ff @(posedge clock) begin
      if (we_c) color_mem_ff[tail_c] <= new_entry;
      color_rd_ff <= color_mem_ff[addr_c];
   end

   always_ff @(posedge clock) begin
      if (we_d) depth_mem_ff[tail_d] <= new_entry;
      depth_rd_ff <= depth_mem_ff[addr_d];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         head_c_ff    <= '0;
         head_d_ff    <= '0;
         cnt_c_ff     <= '0;
         cnt_d_ff     <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         head_c_ff    <= head_c_in;
         head_d_ff    <= head_d_in;
         cnt_c_ff     <= cnt_c_in;
         cnt_d_ff     <= cnt_d_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff      <= sid_in;
      tag_ff      <= tag_in;
      sec_ff      <= sec_in;
      usec_ff     <= usec_in;
      prod_ff     <= prod_in;
      ci_ff       <= ci_in;
      di_ff       <= di_in;
      match_ff    <= match_in;
      drop_ff     <= drop_in;
      ctag_ff     <= ctag_in;
      dtag_ff     <= dtag_in;
      pnum_ff     <= pnum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== tb/sv/timestamp_frame_pair_matcher_test.sv =====
// ----------------------------------------------------------------------------
// Timestamp frame pair matcher test
// Feeds color and depth frame notices through the request stream and
// compares every response word against a predictor of the two frame queues
// and the pair scan. The run covers several window settings, random idling
// on both streams, a long response hold-off and queue overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_frame_pair_matcher_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_SLOTS = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam longint unsigned USEC_SCALE = 64'd1000000;

   typedef enum bit {COLOR_STREAM = 1'b0, DEPTH_STREAM = 1'b1} stream_type;

   typedef struct {
      stream_type stream;
      bit [15:0]  tag;
      bit [31:0]  sec;
      bit [19:0]  usec;
   } frame_notice_type;

   typedef struct {
      bit [15:0]         tag;
      longint unsigned   stamp;
   } frame_entry_type;

   typedef struct {
      bit         matched;
      bit [15:0]  color_tag;
      bit [15:0]  depth_tag;
      bit [15:0]  pair_number;
      bit         dropped;
   } pair_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // frame_tag[15:0], time_sec[47:16], time_usec[67:48], zero pad [71:68]
   logic [tfpm_pkg::REQ_DATA_W-1:0]     req_tdata = '0;
   // stream_id
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // color_tag[15:0], depth_tag[31:16], pair_number[47:32], dropped[48], pad
   logic [tfpm_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   // matched
   logic                                rsp_tuser;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [tfpm_pkg::WIN_W-1:0]          csr_data = '0;

   frame_notice_type   pending_notices[$];
   frame_notice_type   offered;
   pair_result_type    expected_pairs[$];

   // predictor state
   frame_entry_type    color_frames[$];
   frame_entry_type    depth_frames[$];
   bit [19:0]          window_us = tfpm_pkg::WINDOW_RESET;
   bit [15:0]          pair_count = '0;

   int send_idle_pct = 17;
   int recv_idle_pct = 55;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int fault_count = 0;
   int cycle_count = 0;

   timestamp_frame_pair_matcher #(.QUEUE_DEPTH(FRAME_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Append the notice, then look for the oldest color frame with a depth
   // frame inside the window and retire both queues up to that pair.
   function automatic pair_result_type pair_frame_notice(input frame_notice_type n);
      pair_result_type   r;
      frame_entry_type   e;
      longint unsigned   ct;
      longint unsigned   dt;
      longint unsigned   diff;
      bit                found;
      int                ci;
      int                di;
      r = '{default: '0};
      e.tag = n.tag;
      e.stamp = 64'(n.sec) * USEC_SCALE + 64'(n.usec);
      if (n.stream == COLOR_STREAM) begin
         if (color_frames.size() >= FRAME_SLOTS) begin
            void'(color_frames.pop_front());
            r.dropped = 1'b1;
         end
         color_frames.insert(color_frames.size(), e);
      end else begin
         if (depth_frames.size() >= FRAME_SLOTS) begin
            void'(depth_frames.pop_front());
            r.dropped = 1'b1;
         end
         depth_frames.insert(depth_frames.size(), e);
      end
      found = 1'b0;
      for (ci = 0; ci < color_frames.size() && !found; ci++) begin
         ct = color_frames[ci].stamp;
         for (di = 0; di < depth_frames.size() && !found; di++) begin
            dt = depth_frames[di].stamp;
            diff = (ct > dt) ? ct - dt : dt - ct;
            if (diff <= 64'(window_us)) begin
               r.matched = 1'b1;
               r.color_tag = color_frames[ci].tag;
               r.depth_tag = depth_frames[di].tag;
               r.pair_number = pair_count;
               pair_count++;
               repeat (di + 1) void'(depth_frames.pop_front());
               repeat (ci + 1) void'(color_frames.pop_front());
               found = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic flag_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   function automatic void push_raw(input stream_type s, input bit [15:0] tag,
                                    input bit [31:0] sec, input bit [19:0] usec);
      frame_notice_type n;
      n.stream = s;
      n.tag = tag;
      n.sec = sec;
      n.usec = usec;
      pending_notices.insert(pending_notices.size(), n);
   endfunction

   function automatic void push_stamp(input stream_type s, input longint unsigned t);
      push_raw(s, 16'($urandom_range(0, 65535)), 32'(t / USEC_SCALE), 20'(t % USEC_SCALE));
   endfunction

   // Mostly color/depth pairs around a running frame clock, with gaps,
   // single-stream runs that overflow a queue, and unrelated noise.
   function automatic void queue_random_notices(input int count);
      int                start;
      int                pick;
      int                run;
      longint unsigned   base;
      longint unsigned   jitter;
      stream_type        s;
      start = pending_notices.size();
      base = 64'($urandom_range(1, 32'hFFFF0000)) * USEC_SCALE
             + 64'($urandom_range(0, 999999));
      while (pending_notices.size() - start < count) begin
         pick = $urandom_range(0, 99);
         base += 64'($urandom_range(20000, 45000));
         if (pick < 70) begin
            jitter = ($urandom_range(0, 3) == 0) ? 0 : 64'($urandom_range(0, 50000));
            if ($urandom_range(0, 1) == 1) begin
               if ($urandom_range(0, 9) != 0) push_stamp(COLOR_STREAM, base);
               if ($urandom_range(0, 9) != 0) push_stamp(DEPTH_STREAM, base + jitter);
            end else begin
               if ($urandom_range(0, 9) != 0) push_stamp(DEPTH_STREAM, base + jitter);
               if ($urandom_range(0, 9) != 0) push_stamp(COLOR_STREAM, base);
            end
         end else if (pick < 85) begin
            s = stream_type'($urandom_range(0, 1));
            run = $urandom_range(1, 10);
            repeat (run) begin
               push_stamp(s, base);
               base += 64'($urandom_range(20000, 45000));
            end
         end else begin
            push_raw(stream_type'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     32'($urandom), 20'($urandom_range(0, 20'hFFFFF)));
         end
      end
   endfunction

   task automatic set_window(input bit [19:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_us = value;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_notices.size() != 0 || req_tvalid || expected_pairs.size() != 0);
   endtask

   // request driver: predict on acceptance, then offer the next word
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_pairs.insert(expected_pairs.size(), pair_frame_notice(offered));
         if (!req_tvalid || req_tready) begin
            if (pending_notices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = pending_notices.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, offered.usec, offered.sec, offered.tag};
               req_tuser <= offered.stream;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off, counted here
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      pair_result_type exp_r;
      pair_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.matched = rsp_tuser;
            got.color_tag = rsp_tdata[15:0];
            got.depth_tag = rsp_tdata[31:16];
            got.pair_number = rsp_tdata[47:32];
            got.dropped = rsp_tdata[48];
            if (expected_pairs.size() == 0) begin
               flag_fault($sformatf("unexpected word: m=%0d c=%h d=%h n=%0d drop=%0d",
                                    got.matched, got.color_tag, got.depth_tag,
                                    got.pair_number, got.dropped));
            end else begin
               exp_r = expected_pairs.pop_front();
               if (got.matched !== exp_r.matched || got.color_tag !== exp_r.color_tag ||
                   got.depth_tag !== exp_r.depth_tag ||
                   got.pair_number !== exp_r.pair_number ||
                   got.dropped !== exp_r.dropped) begin
                  flag_fault($sformatf({"pair mismatch: expected m=%0d c=%h d=%h n=%0d ",
                                        "drop=%0d, got m=%0d c=%h d=%h n=%0d drop=%0d"},
                                       exp_r.matched, exp_r.color_tag, exp_r.depth_tag,
                                       exp_r.pair_number, exp_r.dropped,
                                       got.matched, got.color_tag, got.depth_tag,
                                       got.pair_number, got.dropped));
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: window at its reset value
      push_raw(COLOR_STREAM, 16'h0000, 32'd0, 20'd0);
      push_raw(DEPTH_STREAM, 16'hFFFF, 32'd0, 20'd33333);
      push_raw(COLOR_STREAM, 16'h0001, 32'd1, 20'd0);
      push_raw(DEPTH_STREAM, 16'h0002, 32'd1, 20'd33334);
      push_raw(DEPTH_STREAM, 16'h0003, 32'd1, 20'd0);
      // microseconds beyond a second carry into the total
      push_raw(COLOR_STREAM, 16'h0004, 32'd5, 20'hFFFFF);
      push_raw(DEPTH_STREAM, 16'h0005, 32'd6, 20'd48575);
      push_raw(COLOR_STREAM, 16'h0006, 32'hFFFFFFFF, 20'd999999);
      push_raw(DEPTH_STREAM, 16'h0007, 32'hFFFFFFFF, 20'hFFFFF);
      push_raw(DEPTH_STREAM, 16'h0008, 32'hFFFFFFFF, 20'd999999);
      // leave a pair behind for the next notice
      push_raw(COLOR_STREAM, 16'h0300, 32'd60, 20'd0);
      push_raw(COLOR_STREAM, 16'h0301, 32'd61, 20'd0);
      push_raw(DEPTH_STREAM, 16'h0302, 32'd60, 20'd100);
      push_raw(DEPTH_STREAM, 16'h0303, 32'd61, 20'd100);
      // overflow the color queue, then match its second-oldest survivor
      for (k = 0; k < FRAME_SLOTS + 1; k++)
         push_raw(COLOR_STREAM, 16'(16'h0100 + k), 32'(100 + k), 20'd0);
      push_raw(DEPTH_STREAM, 16'h0200, 32'd102, 20'd500);
      wait_drained();

      set_window(20'd0);
      queue_random_notices(100);
      wait_drained();

      set_window(20'hFFFFF);
      hold_requests = hold_requests + 1;
      queue_random_notices(100);
      wait_drained();

      send_idle_pct = 55;
      recv_idle_pct = 17;
      set_window(20'd1000000);
      queue_random_notices(100);
      wait_drained();

      set_window(20'($urandom_range(1, 60000)));
      queue_random_notices(100);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_window(20'd33333);
      queue_random_notices(100);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pairs.size() != 0)
         flag_fault($sformatf("%0d expected words never arrived", expected_pairs.size()));
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
